// ===== rtl/core/lpfcrc_pkg.sv =====
// shared types, codes and the crc-32 lookup table for the frame receiver
package lpfcrc_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [7:0]  LEGACY_LO = 8'h41;
    localparam logic [7:0]  LEGACY_HI = 8'h7A;
    localparam logic [7:0]  MAX_LEN_RESET = 8'd250;
    localparam int unsigned CRC_BYTES = 4;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_LEGACY = 3'd1,
        EV_OK     = 3'd2,
        EV_CRCERR = 3'd3,
        EV_LENREJ = 3'd4
    } event_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_LEN_LO  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_CRC     = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [7:0] frame_length;
        logic [7:0] payload_index;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] command_byte;
        event_t     frame_event;
    } result_t;

    typedef logic [31:0] crc_table_t [256];

    function automatic crc_table_t crc_table_gen();
        crc_table_t tbl;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int k = 0; k < 8; k++) begin
                if (c[0]) begin
                    c = (c >> 1) ^ CRC_POLY;
                end else begin
                    c = c >> 1;
                end
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_table_gen();

    // one byte of the reflected crc through the lookup table
    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        return (c >> 8) ^ CRC_TABLE[c[7:0] ^ b];
    endfunction

endpackage

// ===== rtl/core/length_prefixed_frame_crc32_receiver_unit.sv =====
// a byte accepted into the input register gives its result on m_* from the result register
// one byte per cycle while m_tready does not stall the result; the phase machine and the table crc step
// both fit between the input register and the result register
// m_tready low holds the result; an empty input register still takes one byte
// reset (aresetn low, synchronous): idle phase, crc all ones, max_payload_len 250
module length_prefixed_frame_crc32_receiver_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // stream input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // stream output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] command_byte, [15:8] payload_byte,
                                   // [23:16] payload_index, [31:24] frame_length
    output logic [3:0]  m_tuser,   // [2:0] frame_event, [3] payload_valid
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg, in_byte_next;
    logic        out_valid_reg, out_valid_next;
    lpfcrc_pkg::result_t out_reg, out_next;
    lpfcrc_pkg::result_t parse_result;
    logic [7:0]  max_len_reg, max_len_next;
    logic        advance;
    logic        cfg_write;

    // result stage moves when its register is empty or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? 32'd0 : {24'd0, max_len_reg};

    always_comb begin
        max_len_next = max_len_reg;
        if (cfg_write && !paddr[2]) begin
            max_len_next = pwdata[7:0];
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_byte_next  = s_tdata;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance) begin
            out_valid_next = in_valid_reg;
            out_next       = parse_result;
        end
    end

    lpfcrc_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance && in_valid_reg),
        .rx_byte         (in_byte_reg),
        .max_payload_len (max_len_reg),
        .result          (parse_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_len_reg   <= lpfcrc_pkg::MAX_LEN_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            max_len_reg   <= max_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.frame_length, out_reg.payload_index,
                       out_reg.payload_byte, out_reg.command_byte};
    assign m_tuser  = {out_reg.payload_valid, out_reg.frame_event};

endmodule

// ===== rtl/core/lpfcrc_parser.sv =====
// frame parser: phase machine, length check, running crc and result decode
module lpfcrc_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           max_payload_len,
    output lpfcrc_pkg::result_t  result
);

    lpfcrc_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  expected_len_reg, expected_len_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [31:0] crc_accum_reg, crc_accum_next;
    logic [31:0] received_crc_reg, received_crc_next;
    logic [7:0]  first_payload_reg, first_payload_next;

    logic [8:0]  count_inc;
    logic [31:0] crc_upd;
    logic [31:0] rx_crc_shift;

    assign count_inc    = byte_count_reg + 9'd1;
    assign crc_upd      = lpfcrc_pkg::crc_step(crc_accum_reg, rx_byte);
    assign rx_crc_shift = {received_crc_reg[23:0], rx_byte};

    always_comb begin
        phase_next         = phase_reg;
        expected_len_next  = expected_len_reg;
        byte_count_next    = byte_count_reg;
        crc_accum_next     = crc_accum_reg;
        received_crc_next  = received_crc_reg;
        first_payload_next = first_payload_reg;
        result             = '0;
        result.frame_event = lpfcrc_pkg::EV_NONE;

        unique case (phase_reg)
            lpfcrc_pkg::PH_LEN_LO: begin
                // expected_len holds the high length byte here
                if (expected_len_reg != 8'd0 || rx_byte == 8'd0 ||
                    rx_byte > max_payload_len) begin
                    result.frame_event  = lpfcrc_pkg::EV_LENREJ;
                    result.frame_length = (expected_len_reg != 8'd0) ? 8'hFF : rx_byte;
                    phase_next          = lpfcrc_pkg::PH_IDLE;
                    expected_len_next   = 8'd0;
                end else begin
                    expected_len_next   = rx_byte;
                    byte_count_next     = 9'd0;
                    crc_accum_next      = lpfcrc_pkg::CRC_INIT;
                    phase_next          = lpfcrc_pkg::PH_PAYLOAD;
                    result.frame_length = rx_byte;
                end
            end
            lpfcrc_pkg::PH_PAYLOAD: begin
                if (byte_count_reg == 9'd0) begin
                    first_payload_next = rx_byte;
                end
                crc_accum_next       = crc_upd;
                result.payload_byte  = rx_byte;
                result.payload_valid = 1'b1;
                result.payload_index = byte_count_reg[7:0];
                result.frame_length  = expected_len_reg;
                if (count_inc >= {1'b0, expected_len_reg}) begin
                    phase_next        = lpfcrc_pkg::PH_CRC;
                    byte_count_next   = 9'd0;
                    received_crc_next = '0;
                end else begin
                    byte_count_next   = count_inc;
                end
            end
            lpfcrc_pkg::PH_CRC: begin
                received_crc_next   = rx_crc_shift;
                byte_count_next     = count_inc;
                result.frame_length = expected_len_reg;
                if (count_inc >= 9'(lpfcrc_pkg::CRC_BYTES)) begin
                    result.frame_event  = (rx_crc_shift == ~crc_accum_reg) ?
                                          lpfcrc_pkg::EV_OK : lpfcrc_pkg::EV_CRCERR;
                    result.command_byte = first_payload_reg;
                    phase_next          = lpfcrc_pkg::PH_IDLE;
                    byte_count_next     = 9'd0;
                    expected_len_next   = 8'd0;
                    crc_accum_next      = lpfcrc_pkg::CRC_INIT;
                end
            end
            default: begin
                if (rx_byte >= lpfcrc_pkg::LEGACY_LO && rx_byte <= lpfcrc_pkg::LEGACY_HI) begin
                    result.frame_event  = lpfcrc_pkg::EV_LEGACY;
                    result.command_byte = rx_byte;
                    phase_next          = lpfcrc_pkg::PH_IDLE;
                end else begin
                    // high length byte
                    expected_len_next = rx_byte;
                    byte_count_next   = 9'd0;
                    phase_next        = lpfcrc_pkg::PH_LEN_LO;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= lpfcrc_pkg::PH_IDLE;
            expected_len_reg  <= 8'd0;
            byte_count_reg    <= 9'd0;
            crc_accum_reg     <= lpfcrc_pkg::CRC_INIT;
            received_crc_reg  <= '0;
            first_payload_reg <= 8'd0;
        end else if (step) begin
            phase_reg         <= phase_next;
            expected_len_reg  <= expected_len_next;
            byte_count_reg    <= byte_count_next;
            crc_accum_reg     <= crc_accum_next;
            received_crc_reg  <= received_crc_next;
            first_payload_reg <= first_payload_next;
        end
    end

endmodule

// ===== rtl/core/lpfcrc_checker.sv =====
// port-level checks on the frame receiver, bound to the top level
module lpfcrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [3:0]  m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a payload byte never comes with a frame event
    a_payload_no_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tuser[2:0] == lpfcrc_pkg::EV_NONE)
        else $error("payload byte carries an event");

    // without a payload byte the byte and index read zero
    a_idle_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[3] |-> m_tdata[15:8] == 8'd0 && m_tdata[23:16] == 8'd0)
        else $error("payload fields set without payload_valid");

    // legacy command reports no frame length
    a_legacy_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == lpfcrc_pkg::EV_LEGACY |-> m_tdata[31:24] == 8'd0)
        else $error("legacy command with nonzero frame length");

endmodule

bind length_prefixed_frame_crc32_receiver_unit lpfcrc_checker u_lpfcrc_checker (.*);
